>>> rtl/core/wsdf_pkg.sv
// Shared constants and types for the websocket frame deframer.
package wsdf_pkg;

  localparam int unsigned CFG_W        = 25;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned LEN_W        = 64;

  localparam logic [CFG_W-1:0] MAX_LEN_RST = 25'd1048576;

  // result action codes
  localparam logic [ACT_W-1:0] ACT_TEXT     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PING     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLOSE    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TOO_LONG = 2'd3;

  // frame opcodes
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last_of_frame;
  } result_t;

endpackage

>>> rtl/core/websocket_frame_deframer_top.sv
// WebSocket frame deframer: byte-serial header parse, unmask and payload output.
//
// Takes one received stream byte per item and returns at most one result per
// byte. Header: opcode in the low nibble of the first byte, mask flag and 7-bit
// length in the second, then an optional 16-bit or 64-bit big-endian length and
// an optional 4-byte mask key. Payload bytes of text and ping frames come out
// unmasked with last_of_frame on the final one; empty text or ping frames give
// one marker item with has_byte low. Close frames give one close item after
// their payload and the parser then swallows every later byte until reset, as
// it does after a too-long item (decoded length above max_payload_len). Other
// opcodes are consumed silently. FIN and RSV bits are ignored.
// Rate: one byte per clock while out_stall is low. The byte lands in an input
// register, then one pass of parse logic around the frame state updates the
// state and loads the result register. The longest path is the 64-bit length
// compare against max_payload_len. in_stall follows out_stall combinationally
// when both stages hold an item. The user must write max_payload_len through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not check.
module websocket_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // config
  input  logic                          cfg_wr_en,
  input  logic [wsdf_pkg::CFG_W-1:0]    cfg_wr_data,
  // byte stream in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsdf_pkg::BYTE_W-1:0]   in_rx_byte,
  // results out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsdf_pkg::ACT_W-1:0]    out_action,
  output logic [wsdf_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                          out_has_byte,
  output logic                          out_last_of_frame
);
  import wsdf_pkg::*;

  // parse phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  // config register
  logic [CFG_W-1:0]  max_len_r;

  // input stage
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              adv;

  // frame state
  logic [2:0]        phase_r,  phase_nxt;
  logic [3:0]        opc_r,    opc_nxt;
  logic              mask_r,   mask_nxt;
  logic [LEN_W-1:0]  rem_r,    rem_nxt;
  logic [2:0]        hcnt_r,   hcnt_nxt;
  logic [31:0]       key_r,    key_nxt;
  logic [1:0]        kpos_r,   kpos_nxt;
  logic              stop_r,   stop_nxt;

  // result stage
  logic              out_vld_r;
  result_t           res_r;
  result_t           res;
  logic              emit;

  // parse temporaries
  logic [LEN_W-1:0]  len_v;
  logic              len_done;
  logic              body_start;
  logic              mask_new;
  logic              too_long;
  logic [2:0]        hcnt_inc;
  logic [6:0]        len7;
  logic [BYTE_W-1:0] key_byte;
  logic [CFG_W-1:0]  rem_dec;
  logic              last;

  // the parse stage moves when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  assign hcnt_inc = hcnt_r + 3'd1;
  assign len7     = in_byte_r[6:0];
  assign rem_dec  = rem_r[CFG_W-1:0] - {{(CFG_W-1){1'b0}}, 1'b1};
  assign mask_new = (phase_r == PH_HDR1) ? in_byte_r[7] : mask_r;

  always_comb begin
    case (kpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    opc_nxt    = opc_r;
    mask_nxt   = mask_r;
    rem_nxt    = rem_r;
    hcnt_nxt   = hcnt_r;
    key_nxt    = key_r;
    kpos_nxt   = kpos_r;
    stop_nxt   = stop_r;
    emit       = 1'b0;
    res        = '0;
    len_v      = rem_r;
    len_done   = 1'b0;
    body_start = 1'b0;
    last       = 1'b0;

    if (!stop_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          opc_nxt   = in_byte_r[3:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = in_byte_r[7];
          key_nxt  = '0;
          rem_nxt  = '0;
          hcnt_nxt = '0;
          if (len7 == 7'd126) begin
            phase_nxt = PH_EXT16;
          end else if (len7 == 7'd127) begin
            phase_nxt = PH_EXT64;
          end else begin
            len_v    = {{(LEN_W-7){1'b0}}, len7};
            rem_nxt  = len_v;
            len_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_v    = {rem_r[LEN_W-BYTE_W-1:0], in_byte_r};
          rem_nxt  = len_v;
          hcnt_nxt = hcnt_inc;
          len_done = (phase_r == PH_EXT16) ? (hcnt_inc == 3'd2) : (hcnt_inc == 3'd0);
        end
        PH_MASK: begin
          key_nxt    = {key_r[23:0], in_byte_r};
          hcnt_nxt   = hcnt_inc;
          body_start = (hcnt_inc >= 3'd4);
        end
        PH_PAYLOAD: begin
          // length passed the limit check, so it fits the low config-width bits
          kpos_nxt = kpos_r + 2'd1;
          rem_nxt  = {{(LEN_W-CFG_W){1'b0}}, rem_dec};
          last     = (rem_dec == '0);
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          if (opc_r == OPC_TEXT) begin
            emit = 1'b1;
            res  = '{ACT_TEXT, in_byte_r ^ key_byte, 1'b1, last};
          end else if (opc_r == OPC_PING) begin
            emit = 1'b1;
            res  = '{ACT_PING, in_byte_r ^ key_byte, 1'b1, last};
          end else if (opc_r == OPC_CLOSE && last) begin
            emit     = 1'b1;
            stop_nxt = 1'b1;
            res      = '{ACT_CLOSE, '0, 1'b0, 1'b1};
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // length complete: limit check, then mask key or body
      too_long = (|len_v[LEN_W-1:CFG_W]) || (len_v[CFG_W-1:0] > max_len_r);
      if (len_done) begin
        if (too_long) begin
          emit      = 1'b1;
          stop_nxt  = 1'b1;
          phase_nxt = PH_HDR0;
          res       = '{ACT_TOO_LONG, '0, 1'b0, 1'b1};
        end else begin
          hcnt_nxt = '0;
          if (mask_new) begin
            phase_nxt = PH_MASK;
          end else begin
            body_start = 1'b1;
          end
        end
      end

      // header done: empty text, ping and close frames end here with a marker item
      if (body_start) begin
        kpos_nxt = '0;
        if (len_v == '0) begin
          phase_nxt = PH_HDR0;
          if (opc_r == OPC_TEXT) begin
            emit = 1'b1;
            res  = '{ACT_TEXT, '0, 1'b0, 1'b1};
          end else if (opc_r == OPC_PING) begin
            emit = 1'b1;
            res  = '{ACT_PING, '0, 1'b0, 1'b1};
          end else if (opc_r == OPC_CLOSE) begin
            emit     = 1'b1;
            stop_nxt = 1'b1;
            res      = '{ACT_CLOSE, '0, 1'b0, 1'b1};
          end
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end else begin
      too_long = 1'b0;
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      opc_r   <= '0;
      mask_r  <= 1'b0;
      rem_r   <= '0;
      hcnt_r  <= '0;
      key_r   <= '0;
      kpos_r  <= '0;
      stop_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
      rem_r   <= rem_nxt;
      hcnt_r  <= hcnt_nxt;
      key_r   <= key_nxt;
      kpos_r  <= kpos_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= emit;
    end else if (out_vld_r && !out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_action        = res_r.action;
  assign out_data_byte     = res_r.data_byte;
  assign out_has_byte      = res_r.has_byte;
  assign out_last_of_frame = res_r.last_of_frame;

endmodule

>>> rtl/core/wsdf_checker.sv
// Port-level checks for the websocket frame deframer, bound to the top level.
module wsdf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [wsdf_pkg::ACT_W-1:0]    out_action,
  input logic [wsdf_pkg::BYTE_W-1:0]   out_data_byte,
  input logic                          out_has_byte,
  input logic                          out_last_of_frame
);
  import wsdf_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_data_byte) && $stable(out_has_byte) && $stable(out_last_of_frame))
    else $error("result item changed while stalled");

  // items without a byte are frame markers and always end the frame
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last_of_frame && out_data_byte == '0)
    else $error("marker item not last or carries data");

  // close and too-long never carry a byte
  a_term_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_CLOSE || out_action == ACT_TOO_LONG) |-> !out_has_byte)
    else $error("terminal item carries a byte");

  // nothing follows a terminal item
  a_term_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_action == ACT_CLOSE || out_action == ACT_TOO_LONG)
      |=> !out_valid)
    else $error("result item after stream end");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_action        (out_action),
  .out_data_byte     (out_data_byte),
  .out_has_byte      (out_has_byte),
  .out_last_of_frame (out_last_of_frame)
);

>>> tb/testbench.sv
// Self-checking testbench for the websocket frame deframer: byte stream in, results checked.
`timescale 1ns / 100ps

module testbench;
  import wsdf_pkg::*;

  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Margin after the block drains, before touching config.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 250;

  // Header walk of the frame parser, mirrored in the testbench parser model below.
  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_LEN16, ST_LEN64, ST_KEY, ST_BODY
  } hdr_state_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ACT_W-1:0]  out_action;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_has_byte;
  logic              out_last_of_frame;

  websocket_frame_deframer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_data_byte     (out_data_byte),
    .out_has_byte      (out_has_byte),
    .out_last_of_frame (out_last_of_frame)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stream bytes waiting to go out, and results the parser owes us.
  logic [7:0] tx_bytes[$];
  result_t    pending_results[$];
  int         bytes_sent = 0;    // queued in tx_bytes
  int         bytes_taken = 0;   // accepted by the block
  int         mismatches = 0;
  int         quiet_cycles = 0;
  logic       in_fire = 1'b0;    // input item accepted at the last rising edge
  logic       calm = 1'b0;       // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Frame parser mirror. State here tracks the block's own frame state.
  // ---------------------------------------------------------------------------
  hdr_state_t       rx_state = ST_HDR0;
  logic [3:0]       cur_opcode = '0;
  logic             cur_masked = 1'b0;
  logic [63:0]      bytes_left = '0;
  logic [2:0]       len_bytes = '0;   // extended length / key bytes seen so far
  logic [31:0]      cur_key = '0;     // first key byte in the top bits
  logic [1:0]       key_idx = '0;
  logic             halted = 1'b0;    // close or too-long seen: rest of stream is dropped
  logic [CFG_W-1:0] max_len = MAX_LEN_RST;

  function automatic void expect_result(logic [ACT_W-1:0] act, logic [7:0] data,
                                        logic has, logic last);
    result_t r;
    r.action        = act;
    r.data_byte     = data;
    r.has_byte      = has;
    r.last_of_frame = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Header and key done. Empty frames finish right here.
  function automatic void open_body();
    key_idx = '0;
    if (bytes_left == 0) begin
      rx_state = ST_HDR0;
      if (cur_opcode == OPC_TEXT) expect_result(ACT_TEXT, '0, 1'b0, 1'b1);
      else if (cur_opcode == OPC_PING) expect_result(ACT_PING, '0, 1'b0, 1'b1);
      else if (cur_opcode == OPC_CLOSE) begin
        halted = 1'b1;
        expect_result(ACT_CLOSE, '0, 1'b0, 1'b1);
      end
    end else begin
      rx_state = ST_BODY;
    end
  endfunction

  // Full length decoded: limit check (strictly greater rejects), then key or body.
  function automatic void length_known();
    if (bytes_left > {39'd0, max_len}) begin
      halted   = 1'b1;
      rx_state = ST_HDR0;
      expect_result(ACT_TOO_LONG, '0, 1'b0, 1'b1);
    end else begin
      len_bytes = '0;
      if (cur_masked) rx_state = ST_KEY;
      else open_body();
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] plain;
    logic [3:0] need;
    if (halted) return;
    case (rx_state)
      ST_HDR0: begin
        cur_opcode = b[3:0];   // FIN/RSV in the top nibble are don't-care
        rx_state   = ST_HDR1;
      end
      ST_HDR1: begin
        cur_masked = b[7];
        cur_key    = '0;
        bytes_left = '0;
        len_bytes  = '0;
        if (b[6:0] == 7'd126) rx_state = ST_LEN16;
        else if (b[6:0] == 7'd127) rx_state = ST_LEN64;
        else begin
          bytes_left = {57'd0, b[6:0]};
          length_known();
        end
      end
      ST_LEN16, ST_LEN64: begin
        need       = (rx_state == ST_LEN16) ? 4'd2 : 4'd8;
        bytes_left = {bytes_left[55:0], b};
        len_bytes  = len_bytes + 3'd1;
        // 3-bit count wraps to zero on the eighth byte
        if (((len_bytes == 3'd0) ? 4'd8 : {1'b0, len_bytes}) == need) length_known();
      end
      ST_KEY: begin
        cur_key   = {cur_key[23:0], b};
        len_bytes = len_bytes + 3'd1;
        if (len_bytes >= 3'd4) open_body();
      end
      ST_BODY: begin
        plain      = b ^ cur_key[(3 - key_idx) * 8 +: 8];
        key_idx    = key_idx + 2'd1;
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 0) rx_state = ST_HDR0;
        if (cur_opcode == OPC_TEXT) expect_result(ACT_TEXT, plain, 1'b1, bytes_left == 0);
        else if (cur_opcode == OPC_PING) expect_result(ACT_PING, plain, 1'b1, bytes_left == 0);
        else if (cur_opcode == OPC_CLOSE && bytes_left == 0) begin
          halted = 1'b1;
          expect_result(ACT_CLOSE, '0, 1'b0, 1'b1);
        end
      end
      default: rx_state = ST_HDR0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Frame builders
  // ---------------------------------------------------------------------------
  function automatic void send_byte(logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
    bytes_sent++;
  endfunction

  // form: 0 = 7-bit length, 1 = 16-bit extended, 2 = 64-bit extended
  function automatic void send_header(logic [3:0] opc, logic [63:0] len, logic masked,
                                      int form, logic [31:0] key);
    logic [3:0] flags;
    flags = 4'($urandom_range(0, 15));
    send_byte({flags, opc});
    case (form)
      0: send_byte({masked, len[6:0]});
      1: begin
        send_byte({masked, 7'd126});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, 7'd127});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
  endfunction

  function automatic void send_body(int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endfunction

  // Short lengths mostly go in 7 bits, now and then in the wider encodings.
  function automatic int pick_form(int len);
    int r;
    if (len > 125) return $urandom_range(1, 2);
    r = $urandom_range(0, 9);
    return (r < 7) ? 0 : (r < 9) ? 1 : 2;
  endfunction

  // One well-formed frame that stays within the limit; never a close.
  function automatic void random_frame(logic [CFG_W-1:0] lim);
    logic [3:0] opc;
    int         len;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) opc = OPC_TEXT;
    else if (pick < 7) opc = OPC_PING;
    else begin
      do opc = 4'($urandom_range(0, 15));
      while (opc == OPC_TEXT || opc == OPC_CLOSE || opc == OPC_PING);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 12);
    else if (pick < 92) len = $urandom_range(13, 140);
    else len = $urandom_range(141, 300);
    if (len > lim) len = $urandom_range(0, lim);
    send_header(opc, 64'(len), 1'($urandom_range(0, 1)), pick_form(len), $urandom);
    send_body(len);
  endfunction

  // Sender holds off until every byte is in and every result is out.
  task automatic wait_idle();
    while (bytes_taken != bytes_sent || pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_len      = v;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one byte per item, new data only after the previous one went in.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= tx_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on input items, check output items.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: action %0d data %0h has_byte %0b last %0b",
                 out_action, out_data_byte, out_has_byte, out_last_of_frame);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_action);
            mismatches++;
          end
          if (out_data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, out_data_byte);
            mismatches++;
          end
          if (out_has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_has_byte);
            mismatches++;
          end
          if (out_last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                   out_last_of_frame);
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hang detector.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] limits[6];
    logic [63:0]      big;
    int               start;
    int               finale;

    // zero, tiny, top bit only, all ones (largest value), then around the 7-bit edge
    limits = '{25'd0, 25'd1, 25'd16777216, 25'h1ffffff, 25'd126, 25'd125};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset limit: empty text, empty masked ping with an
    // all-ones key, text with extreme bytes, ping in 16-bit form with a zero
    // key, and a silent frame of another opcode.
    send_header(OPC_TEXT, 64'd0, 1'b0, 0, 32'h0);
    send_header(OPC_PING, 64'd0, 1'b1, 0, 32'hffff_ffff);
    send_header(OPC_TEXT, 64'd3, 1'b0, 0, 32'h0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h5a);
    send_header(OPC_PING, 64'd1, 1'b1, 1, 32'h0);
    send_byte(8'ha5);
    send_header(4'h2, 64'd1, 1'b0, 0, 32'h0);
    send_byte(8'hff);
    wait_idle();

    // Random frames under a series of limits; each phase drains fully before
    // the next register write. One phase runs with no idling at all.
    foreach (limits[p]) begin
      set_limit(limits[p]);
      calm  = (p == 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_frame(limits[p]);
      wait_idle();
      calm = 1'b0;
    end

    // The stream can be stopped only once per reset: end on either a close
    // frame or a too-long header, then show that later bytes are dropped.
    finale = $urandom_range(0, 3);
    if (finale < 2) begin
      big = 64'($urandom_range(0, 6));
      send_header(OPC_CLOSE, big, 1'($urandom_range(0, 1)), pick_form(int'(big)), $urandom);
      send_body(int'(big));
    end else if (finale == 2) begin
      // one past the limit
      big = max_len + 64'd1;
      send_header(($urandom_range(0, 1) != 0) ? OPC_TEXT : OPC_PING, big,
                  1'($urandom_range(0, 1)), pick_form(int'(big)), $urandom);
    end else begin
      // huge 64-bit length, top bit set
      big = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      send_header(OPC_TEXT, big, 1'b1, 2, $urandom);
    end
    send_body(8);
    wait_idle();
    repeat (8) @(negedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> websocket_frame_deframer_top.f
rtl/core/wsdf_pkg.sv
rtl/core/websocket_frame_deframer_top.sv
rtl/core/wsdf_checker.sv
tb/testbench.sv
